>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RPN calculator RTL.
// Each macro expects the signals clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge once reset has been released.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every rising edge, also while reset is held.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hw/rtl/rpn_pkg.sv
// Shared types, codes and constants for the RPN stack calculator.
// Depends on nothing; used by rpn_div, rpn_dp, rpn_ctrl and the top level.
`default_nettype none

package rpn_pkg;

    localparam int STACK_DEPTH_DEFAULT = 16;
    localparam int DATA_W              = 32;
    localparam int FRAC_W              = 16;
    localparam int WIDE_W              = 2 * DATA_W;
    localparam int QUOT_W              = DATA_W + FRAC_W;
    localparam int DEPTH_OUT_W         = 5;
    localparam int ACTION_W            = 3;
    localparam int STATUS_W            = 3;

    // Action codes; the two remaining codes are invalid.
    localparam logic [ACTION_W-1:0] ACT_PUSH  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_ADD   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_SUB   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_MUL   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_DIV   = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_DRAIN = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DIV_ZERO    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_INVALID     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_EMPTY_DRAIN = 3'd5;
    localparam logic [STATUS_W-1:0] ST_SATURATED   = 3'd6;

    typedef struct packed {
        logic [ACTION_W-1:0]      action;
        logic signed [DATA_W-1:0] operand_value;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] top_value;
        logic [STATUS_W-1:0]      status;
        logic [DEPTH_OUT_W-1:0]   depth_now;
        logic                     last_of_run;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_READ_TOP,
        S_RD_B,
        S_RD_A,
        S_EXEC,
        S_DIV_WAIT,
        S_SAT,
        S_DRAIN_RD,
        S_EMIT
    } state_t;

    typedef enum logic [2:0] {
        RES_ZERO,
        RES_OPERAND,
        RES_RDATA,
        RES_B,
        RES_SAT
    } res_sel_t;

    typedef struct packed {
        logic                load_item;
        logic                rd_second;
        logic                latch_b;
        logic                latch_a;
        logic                alu_go;
        logic                div_start;
        logic                div_load;
        logic                wr_push;
        logic                wr_result;
        logic                sp_dec;
        logic                res_load;
        res_sel_t            res_sel;
        logic [STATUS_W-1:0] res_status;
        logic                res_last;
        logic                out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                sp_zero;
        logic                sp_one;
        logic                sp_lt2;
        logic                sp_full;
        logic                b_zero;
        logic                div_done;
        logic                sat;
        logic                res_last;
        logic                out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/rpn_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; used for the calculator's stack storage.
`default_nettype none

module rpn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                      wr_data,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> hw/rtl/rpn_div.sv
// Iterative signed Q16.16 divider: one quotient bit per cycle, truncating toward zero.
// Depends on rpn_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rpn_div (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic signed [rpn_pkg::DATA_W-1:0] dividend,
    input  wire logic signed [rpn_pkg::DATA_W-1:0] divisor,
    output logic                                   done,
    output logic signed [rpn_pkg::QUOT_W:0]        quotient
);

    localparam int DW    = rpn_pkg::DATA_W;
    localparam int QW    = rpn_pkg::QUOT_W;
    localparam int CNT_W = $clog2(QW + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]    rem_reg, rem_next;
    logic [QW-1:0]    num_reg, num_next;
    logic [DW-1:0]    den_reg, den_next;
    logic             neg_reg, neg_next;

    logic [DW-1:0]    mag_a;
    logic [DW-1:0]    mag_b;
    logic [DW:0]      trial;
    logic [DW:0]      diff;
    logic [QW:0]      q_ext;

    assign mag_a = dividend[DW-1] ? (DW'(0) - dividend) : dividend;
    assign mag_b = divisor[DW-1] ? (DW'(0) - divisor) : divisor;

    // The partial remainder stays below the divisor, so DW bits hold it.
    assign trial = {rem_reg, num_reg[QW-1]};
    assign diff  = trial - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(QW);
            rem_next  = '0;
            num_next  = {mag_a, {rpn_pkg::FRAC_W{1'b0}}};
            den_next  = mag_b;
            neg_next  = dividend[DW-1] ^ divisor[DW-1];
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
            if (!diff[DW])
            begin
                rem_next = diff[DW-1:0];
                num_next = {num_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DW-1:0];
                num_next = {num_reg[QW-2:0], 1'b0};
            end
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        num_reg <= num_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign q_ext    = {1'b0, num_reg};
    assign quotient = neg_reg ? $signed((QW + 1)'(0) - q_ext) : $signed(q_ext);
    assign done     = done_reg;

    `ASSERT_CLK(a_div_busy_count, busy_reg |-> cnt_reg != '0, "divider busy with zero count")

endmodule

`default_nettype wire

>>> hw/rtl/rpn_dp.sv
// Datapath of the RPN calculator: stack pointer, stack RAM, operand and ALU
// registers, saturation, result staging and output register.
// Depends on rpn_pkg, rpn_ram, rpn_div and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rpn_dp #(
    parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire rpn_pkg::in_item_t  item,
    input  wire rpn_pkg::dp_cmd_t   cmd,
    output rpn_pkg::dp_stat_t       stat,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output rpn_pkg::out_item_t      result
);

    localparam int DW   = rpn_pkg::DATA_W;
    localparam int WW   = rpn_pkg::WIDE_W;
    localparam int DOW  = rpn_pkg::DEPTH_OUT_W;
    localparam int AW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SP_W = $clog2(STACK_DEPTH + 1);

    logic [rpn_pkg::ACTION_W-1:0] action_reg, action_next;
    logic signed [DW-1:0]         operand_reg, operand_next;
    logic [SP_W-1:0]              sp_reg, sp_next;
    logic signed [DW-1:0]         a_reg, a_next;
    logic signed [DW-1:0]         b_reg, b_next;
    logic signed [WW-1:0]         alu_reg, alu_next;
    logic signed [DW-1:0]         res_val_reg, res_val_next;
    logic [rpn_pkg::STATUS_W-1:0] res_st_reg, res_st_next;
    logic                         res_last_reg, res_last_next;
    logic                         out_valid_reg, out_valid_next;
    rpn_pkg::out_item_t           out_reg, out_next;

    logic [SP_W-1:0]              sp_m1;
    logic [SP_W-1:0]              sp_m2;
    logic [SP_W+DOW-1:0]          sp_ext;
    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    logic [DW-1:0]                wr_data;
    logic [AW-1:0]                rd_addr;
    logic [DW-1:0]                rd_data;
    logic                         div_done;
    logic signed [rpn_pkg::QUOT_W:0] div_q;
    logic signed [WW-1:0]         prod;
    logic signed [WW-1:0]         a_wide;
    logic signed [WW-1:0]         b_wide;
    logic signed [WW-1:0]         scaled;
    logic                         over;
    logic                         under;
    logic signed [DW-1:0]         sat_val;
    logic                         out_free;

    assign sp_m1  = sp_reg - SP_W'(1);
    assign sp_m2  = sp_reg - SP_W'(2);
    assign sp_ext = {{DOW{1'b0}}, sp_reg};

    // Stack storage: a push writes above the top, a binary operation writes
    // its result over the lower operand.
    assign wr_en   = cmd.wr_push || cmd.wr_result;
    assign wr_addr = cmd.wr_push ? sp_reg[AW-1:0] : sp_m2[AW-1:0];
    assign wr_data = cmd.wr_push ? operand_reg : sat_val;
    assign rd_addr = cmd.rd_second ? sp_m2[AW-1:0] : sp_m1[AW-1:0];

    rpn_ram #(
        .WIDTH (DW),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rpn_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (a_reg),
        .divisor  (b_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign a_wide = WW'(a_reg);
    assign b_wide = WW'(b_reg);
    assign prod   = a_reg * b_reg;

    // A product carries 32 fraction bits; the shift drops 16 of them, rounding down.
    assign scaled = (action_reg == rpn_pkg::ACT_MUL) ? (alu_reg >>> rpn_pkg::FRAC_W) : alu_reg;
    assign over   = !scaled[WW-1] && (|scaled[WW-2:DW-1]);
    assign under  = scaled[WW-1] && !(&scaled[WW-2:DW-1]);

    always_comb
    begin
        if (over)
        begin
            sat_val = {1'b0, {(DW-1){1'b1}}};
        end
        else if (under)
        begin
            sat_val = {1'b1, {(DW-1){1'b0}}};
        end
        else
        begin
            sat_val = scaled[DW-1:0];
        end
    end

    assign out_free = !out_valid_reg || !result_stall;

    always_comb
    begin
        action_next   = action_reg;
        operand_next  = operand_reg;
        sp_next       = sp_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        alu_next      = alu_reg;
        res_val_next  = res_val_reg;
        res_st_next   = res_st_reg;
        res_last_next = res_last_reg;
        out_next      = out_reg;
        out_valid_next = out_valid_reg && result_stall;

        if (cmd.load_item)
        begin
            action_next  = item.action;
            operand_next = item.operand_value;
        end
        if (cmd.wr_push)
        begin
            sp_next = sp_reg + SP_W'(1);
        end
        else if (cmd.wr_result || cmd.sp_dec)
        begin
            sp_next = sp_m1;
        end
        if (cmd.latch_b)
        begin
            b_next = rd_data;
        end
        if (cmd.latch_a)
        begin
            a_next = rd_data;
        end
        if (cmd.alu_go)
        begin
            case (action_reg)
                rpn_pkg::ACT_ADD: alu_next = a_wide + b_wide;
                rpn_pkg::ACT_SUB: alu_next = a_wide - b_wide;
                default:          alu_next = prod;
            endcase
        end
        else if (cmd.div_load)
        begin
            alu_next = WW'(div_q);
        end
        if (cmd.res_load)
        begin
            case (cmd.res_sel)
                rpn_pkg::RES_OPERAND: res_val_next = operand_reg;
                rpn_pkg::RES_RDATA:   res_val_next = rd_data;
                rpn_pkg::RES_B:       res_val_next = b_reg;
                rpn_pkg::RES_SAT:     res_val_next = sat_val;
                default:              res_val_next = '0;
            endcase
            res_st_next   = cmd.res_status;
            res_last_next = cmd.res_last;
        end
        if (cmd.out_load)
        begin
            out_valid_next        = 1'b1;
            out_next.top_value    = res_val_reg;
            out_next.status       = res_st_reg;
            out_next.depth_now    = sp_ext[DOW-1:0];
            out_next.last_of_run  = res_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sp_reg        <= sp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg   <= action_next;
        operand_reg  <= operand_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        alu_reg      <= alu_next;
        res_val_reg  <= res_val_next;
        res_st_reg   <= res_st_next;
        res_last_reg <= res_last_next;
        out_reg      <= out_next;
    end

    always_comb
    begin
        stat.action   = action_reg;
        stat.sp_zero  = (sp_reg == '0);
        stat.sp_one   = (sp_reg == SP_W'(1));
        stat.sp_lt2   = (sp_reg < SP_W'(2));
        stat.sp_full  = (sp_reg >= SP_W'(STACK_DEPTH));
        stat.b_zero   = (b_reg == '0);
        stat.div_done = div_done;
        stat.sat      = over || under;
        stat.res_last = res_last_reg;
        stat.out_free = out_free;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    `ASSERT_CLK(a_dp_sp_bound, sp_reg <= SP_W'(STACK_DEPTH), "stack pointer beyond depth")
    `ASSERT_CLK(a_dp_push_room, cmd.wr_push |-> !stat.sp_full, "push written into a full stack")
    `ASSERT_CLK(a_dp_load_free, cmd.out_load |-> out_free, "output loaded over a held transaction")

endmodule

`default_nettype wire

>>> hw/rtl/rpn_ctrl.sv
// Controller state machine of the RPN calculator; sequences the datapath per item.
// Depends on rpn_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rpn_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire rpn_pkg::dp_stat_t stat,
    output rpn_pkg::dp_cmd_t       cmd
);

    rpn_pkg::state_t              state_reg, state_next;
    logic [rpn_pkg::STATUS_W-1:0] code_reg, code_next;
    logic                         in_emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rpn_pkg::S_IDLE;
            code_reg  <= rpn_pkg::ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    assign item_stall = (state_reg != rpn_pkg::S_IDLE);
    assign in_emit    = (state_reg == rpn_pkg::S_EMIT);

    always_comb
    begin
        logic [rpn_pkg::STATUS_W-1:0] report;
        logic                         do_report;

        state_next     = state_reg;
        code_next      = code_reg;
        cmd            = '0;
        cmd.res_sel    = rpn_pkg::RES_ZERO;
        cmd.res_status = rpn_pkg::ST_OK;
        report         = rpn_pkg::ST_OK;
        do_report      = 1'b0;

        case (state_reg)
            rpn_pkg::S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = rpn_pkg::S_DECODE;
                end
            end
            rpn_pkg::S_DECODE:
            begin
                case (stat.action)
                    rpn_pkg::ACT_PUSH:
                    begin
                        if (stat.sp_full)
                        begin
                            report    = rpn_pkg::ST_OVERFLOW;
                            do_report = 1'b1;
                        end
                        else
                        begin
                            cmd.wr_push  = 1'b1;
                            cmd.res_load = 1'b1;
                            cmd.res_sel  = rpn_pkg::RES_OPERAND;
                            cmd.res_last = 1'b1;
                            state_next   = rpn_pkg::S_EMIT;
                        end
                    end
                    rpn_pkg::ACT_ADD, rpn_pkg::ACT_SUB, rpn_pkg::ACT_MUL, rpn_pkg::ACT_DIV:
                    begin
                        if (stat.sp_lt2)
                        begin
                            report    = rpn_pkg::ST_UNDERFLOW;
                            do_report = 1'b1;
                        end
                        else
                        begin
                            state_next = rpn_pkg::S_RD_B;
                        end
                    end
                    rpn_pkg::ACT_DRAIN:
                    begin
                        if (stat.sp_zero)
                        begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = rpn_pkg::ST_EMPTY_DRAIN;
                            cmd.res_last   = 1'b1;
                            state_next     = rpn_pkg::S_EMIT;
                        end
                        else
                        begin
                            state_next = rpn_pkg::S_DRAIN_RD;
                        end
                    end
                    default:
                    begin
                        report    = rpn_pkg::ST_INVALID;
                        do_report = 1'b1;
                    end
                endcase
                // An error reports the current top: zero on an empty stack,
                // otherwise the entry read at the top address this cycle.
                if (do_report)
                begin
                    if (stat.sp_zero)
                    begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = report;
                        cmd.res_last   = 1'b1;
                        state_next     = rpn_pkg::S_EMIT;
                    end
                    else
                    begin
                        code_next  = report;
                        state_next = rpn_pkg::S_READ_TOP;
                    end
                end
            end
            rpn_pkg::S_READ_TOP:
            begin
                cmd.res_load   = 1'b1;
                cmd.res_sel    = rpn_pkg::RES_RDATA;
                cmd.res_status = code_reg;
                cmd.res_last   = 1'b1;
                state_next     = rpn_pkg::S_EMIT;
            end
            rpn_pkg::S_RD_B:
            begin
                cmd.latch_b   = 1'b1;
                cmd.rd_second = 1'b1;
                state_next    = rpn_pkg::S_RD_A;
            end
            rpn_pkg::S_RD_A:
            begin
                cmd.latch_a = 1'b1;
                state_next  = rpn_pkg::S_EXEC;
            end
            rpn_pkg::S_EXEC:
            begin
                if (stat.action == rpn_pkg::ACT_DIV)
                begin
                    if (stat.b_zero)
                    begin
                        cmd.res_load   = 1'b1;
                        cmd.res_sel    = rpn_pkg::RES_B;
                        cmd.res_status = rpn_pkg::ST_DIV_ZERO;
                        cmd.res_last   = 1'b1;
                        state_next     = rpn_pkg::S_EMIT;
                    end
                    else
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = rpn_pkg::S_DIV_WAIT;
                    end
                end
                else
                begin
                    cmd.alu_go = 1'b1;
                    state_next = rpn_pkg::S_SAT;
                end
            end
            rpn_pkg::S_DIV_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.div_load = 1'b1;
                    state_next   = rpn_pkg::S_SAT;
                end
            end
            rpn_pkg::S_SAT:
            begin
                cmd.wr_result  = 1'b1;
                cmd.res_load   = 1'b1;
                cmd.res_sel    = rpn_pkg::RES_SAT;
                cmd.res_status = stat.sat ? rpn_pkg::ST_SATURATED : rpn_pkg::ST_OK;
                cmd.res_last   = 1'b1;
                state_next     = rpn_pkg::S_EMIT;
            end
            rpn_pkg::S_DRAIN_RD:
            begin
                cmd.sp_dec   = 1'b1;
                cmd.res_load = 1'b1;
                cmd.res_sel  = rpn_pkg::RES_RDATA;
                cmd.res_last = stat.sp_one;
                state_next   = rpn_pkg::S_EMIT;
            end
            rpn_pkg::S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    // Only a drain leaves results pending after this one.
                    state_next = stat.res_last ? rpn_pkg::S_IDLE : rpn_pkg::S_DRAIN_RD;
                end
            end
            default:
            begin
                state_next = rpn_pkg::S_IDLE;
            end
        endcase
    end

    `ASSERT_CLK(a_ctrl_emit_leaves, in_emit && stat.out_free |=> !in_emit, "emit state held")

endmodule

`default_nettype wire

>>> hw/rtl/rpn_stack_calculator_top.sv
// Top level of the RPN stack calculator: controller plus datapath.
// Depends on rpn_pkg, rpn_ctrl and rpn_dp.
`default_nettype none

// Reverse Polish evaluator on a stack of signed Q16.16 values. Each input
// transaction pushes a value, combines the top two entries (add, subtract,
// multiply, divide) or drains the stack top to bottom; every transaction
// yields one result, except a drain of a non-empty stack, which yields one
// per entry with last_of_run set on the final one. Items are handled one at
// a time; a divide runs the divider's 48-step quotient loop. The stack
// lives in a RAM with a registered read port, so the two operands of an
// operation are read one after the other. A finished result waits in the
// output register while the next item is accepted; a stalled output holds
// up the calculator only when the next result is ready while the previous
// one is still held.
module rpn_stack_calculator_top #(
    parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_stall,
    input  wire rpn_pkg::in_item_t  item,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output rpn_pkg::out_item_t      result
);

    rpn_pkg::dp_cmd_t  cmd;
    rpn_pkg::dp_stat_t stat;

    rpn_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    rpn_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire
